>>> rtl/core/bgdsr_pkg.sv
// Shared types, constants and helpers of the bar graph dirty span renderer.
// Depends on nothing; every other file of the block imports it.
package bgdsr_pkg;

  // fixed field widths
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned SCOL_W   = 8;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // panel geometry
  localparam int unsigned PANEL_COLUMNS_DEF = 128;
  localparam int unsigned BYTES_PER_RESULT  = 16;
  localparam int unsigned COL_W             = 7;
  localparam int unsigned ROW_W             = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_OFFSET = 3'd5;

  // dirty span handed from the span unit to the sequencer
  typedef struct packed {
    logic             none;   // nothing to draw
    logic [COL_W-1:0] xs;     // first bar-relative column
    logic [COL_W-1:0] xe;     // last bar-relative column
  } span_t;

  // rows of one page covered by the bar rows y0..y1
  function automatic logic [7:0] row_mask(input logic [PAGE_W-1:0] pg,
                                          input logic [ROW_W-1:0] y0,
                                          input logic [ROW_W-1:0] y1);
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bot;
    logic [ROW_W-1:0] lo_r;
    logic [ROW_W-1:0] hi_r;
    logic [2:0]       lo;
    logic [2:0]       hi;
    top = {pg, 3'b000};
    bot = {pg, 3'b111};
    lo_r = (y0 > top) ? y0 : top;
    hi_r = (y1 < bot) ? y1 : bot;
    lo = lo_r[2:0];
    hi = hi_r[2:0];
    if (y1 < top || y0 > bot) begin
      row_mask = 8'h00;
    end else begin
      row_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    end
  endfunction

endpackage

>>> rtl/core/bgdsr_if.sv
// Valid/ready channel interfaces of the bar graph dirty span renderer:
// bar update in, packed column bytes out, register writes. Uses bgdsr_pkg.
interface bgdsr_upd_if import bgdsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] peak;

  modport source (output valid, level, peak, input ready);
  modport sink   (input valid, level, peak, output ready);
endinterface

interface bgdsr_res_if import bgdsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PAGE_W-1:0]  page;
  logic [SCOL_W-1:0]  start_column;
  logic [COUNT_W-1:0] byte_count;
  logic [HALF_W-1:0]  bytes_low;
  logic [HALF_W-1:0]  bytes_high;
  logic               page_start;
  logic               last;

  modport source (output valid, page, start_column, byte_count, bytes_low, bytes_high,
                  page_start, last, input ready);
  modport sink   (input valid, page, start_column, byte_count, bytes_low, bytes_high,
                  page_start, last, output ready);
endinterface

interface bgdsr_cfg_if import bgdsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/bgdsr_span.sv
// Dirty span unit: merges old and new level and peak into a column range,
// widens it or takes the whole bar, caps it at the bar and panel edge. Uses bgdsr_pkg.
module bgdsr_span import bgdsr_pkg::*; #(
  parameter int unsigned PANEL_COLUMNS = PANEL_COLUMNS_DEF
) (
  input  logic               full_i,
  input  logic [LEVEL_W-1:0] width_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [LEVEL_W-1:0] peak_i,
  input  logic [LEVEL_W-1:0] prev_level_i,
  input  logic [LEVEL_W-1:0] prev_peak_i,
  input  logic [COL_W-1:0]   bar_left_i,
  output span_t              span_o
);

  localparam logic [LEVEL_W-1:0] PanelCols = LEVEL_W'(PANEL_COLUMNS);
  localparam logic [LEVEL_W-1:0] PanelLast = LEVEL_W'(PANEL_COLUMNS - 1);

  logic [LEVEL_W-1:0] a_lo, a_hi, p_lo, p_hi, lo, hi;
  logic [LEVEL_W-1:0] xs, xe, clip_end, w_last;
  logic [LEVEL_W:0]   hi_inc;
  logic               off_panel;

  // union of old and new positions
  always_comb begin
    a_lo = (level_i < prev_level_i) ? level_i : prev_level_i;
    a_hi = (level_i > prev_level_i) ? level_i : prev_level_i;
    p_lo = (peak_i < prev_peak_i) ? peak_i : prev_peak_i;
    p_hi = (peak_i > prev_peak_i) ? peak_i : prev_peak_i;
    lo   = (a_lo < p_lo) ? a_lo : p_lo;
    hi   = (a_hi > p_hi) ? a_hi : p_hi;
  end

  // widen three left and one right, or take the whole bar
  always_comb begin
    w_last = width_i - 8'd1;
    hi_inc = {1'b0, hi} + 9'd1;
    if (full_i) begin
      xs = '0;
      xe = w_last;
    end else begin
      xs = (lo >= 8'd3) ? lo - 8'd3 : '0;
      xe = (hi_inc < {1'b0, width_i}) ? hi_inc[LEVEL_W-1:0] : w_last;
    end
  end

  // panel edge clip
  always_comb begin
    off_panel = {1'b0, bar_left_i} >= PanelCols;
    clip_end  = PanelLast - {1'b0, bar_left_i};
    span_o.xe = (xe > clip_end) ? clip_end[COL_W-1:0] : xe[COL_W-1:0];
    span_o.xs = xs[COL_W-1:0];
    span_o.none = off_panel || (xs > ((xe > clip_end) ? clip_end : xe));
  end

endmodule

>>> rtl/core/bgdsr_col_unit.sv
// Column byte unit: renders the sixteen column bytes of one result from
// the chunk's first column, the page row mask, level and peak. Uses bgdsr_pkg.
module bgdsr_col_unit import bgdsr_pkg::*; (
  input  logic [COL_W-1:0]   xi_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic [ROW_W-1:0]   y0_i,
  input  logic [ROW_W-1:0]   y1_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [LEVEL_W-1:0] peak_i,
  input  logic               segmented_i,
  output logic [HALF_W-1:0]  bytes_low_o,
  output logic [HALF_W-1:0]  bytes_high_o
);

  logic [7:0]                      mask;
  logic [LEVEL_W-1:0]              pk_m1, pk_m2;
  logic [BYTES_PER_RESULT*8-1:0]   lanes;

  assign mask  = row_mask(page_i, y0_i, y1_i);
  assign pk_m1 = peak_i - 8'd1;
  assign pk_m2 = peak_i - 8'd2;

  // one lane per byte of the result
  always_comb begin
    logic [LEVEL_W-1:0] col;
    logic [7:0]         b;
    lanes = '0;
    for (int k = 0; k < BYTES_PER_RESULT; k++) begin
      col = LEVEL_W'(xi_i) + LEVEL_W'(k);
      b = '0;
      if (col < level_i && !(segmented_i && col[1:0] == 2'b11)) begin
        b = mask;
      end
      if (peak_i != '0 && (col == pk_m1 || (peak_i >= 8'd2 && col == pk_m2))) begin
        b = b ^ mask;
      end
      if (COUNT_W'(k) < count_i) begin
        lanes[k*8 +: 8] = b;
      end
    end
  end

  assign bytes_low_o  = lanes[HALF_W-1:0];
  assign bytes_high_o = lanes[2*HALF_W-1:HALF_W];

endmodule

>>> rtl/core/bar_graph_dirty_span_renderer.sv
// Bar graph dirty span renderer top: register file, sequencer, output register.
// Sequence: an update transfer goes through the clamp and span states, then one result per
// cycle is loaded while res_o is not stalled, each a 16-byte chunk from the single column
// byte unit; N up to 64 results (pages x chunks), new update taken only when idle.
// Reset: registers take their defaults, stored level and peak clear, first update
// after reset redraws the full bar width.
module bar_graph_dirty_span_renderer import bgdsr_pkg::*; #(
  parameter int unsigned PANEL_COLUMNS = PANEL_COLUMNS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bgdsr_cfg_if.sink    cfg_i,
  bgdsr_upd_if.sink    upd_i,
  bgdsr_res_if.source  res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLAMP = 2'd1;
  localparam logic [1:0] S_SPAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [LEVEL_W-1:0] PanelCols = LEVEL_W'(PANEL_COLUMNS);

  // configuration registers
  logic [COL_W-1:0]   bar_left_q;
  logic [LEVEL_W-1:0] bar_width_q;
  logic [ROW_W-1:0]   bar_top_q;
  logic [6:0]         bar_height_q;
  logic               segmented_q;
  logic [1:0]         ram_offset_q;

  // sequencer and item state
  logic [1:0]         state_q, state_d;
  logic [LEVEL_W-1:0] lvl_in_q, pk_in_q;
  logic [LEVEL_W-1:0] lvl_q, pk_q, width_q;
  logic [ROW_W-1:0]   y1_q;
  logic [LEVEL_W-1:0] prev_level_q, prev_peak_q;
  logic               full_q;
  logic [COL_W-1:0]   xs_q, xe_q, xi_q;
  logic [PAGE_W-1:0]  pg_q;
  logic               first_q;

  // output register
  logic               res_valid_q;
  logic [PAGE_W-1:0]  res_page_q;
  logic [SCOL_W-1:0]  res_scol_q;
  logic [COUNT_W-1:0] res_count_q;
  logic [HALF_W-1:0]  res_low_q, res_high_q;
  logic               res_pstart_q, res_last_q;

  span_t              span;
  logic               upd_xfer, load;
  logic [COL_W-1:0]   remain;
  logic               row_done, item_done;
  logic [COUNT_W-1:0] count;
  logic [HALF_W-1:0]  bytes_low, bytes_high;
  logic [LEVEL_W-1:0] w_eff;
  logic [6:0]         h_eff;
  logic [LEVEL_W-1:0] y1_raw;
  logic [8:0]         scol_sum;

  assign cfg_i.ready = 1'b1;
  assign upd_i.ready = (state_q == S_IDLE);
  assign upd_xfer    = upd_i.valid && upd_i.ready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_left_q   <= '0;
      bar_width_q  <= 8'd128;
      bar_top_q    <= '0;
      bar_height_q <= 7'd22;
      segmented_q  <= 1'b1;
      ram_offset_q <= 2'd2;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BAR_LEFT:   bar_left_q   <= cfg_i.data[COL_W-1:0];
        CFG_BAR_WIDTH:  bar_width_q  <= cfg_i.data;
        CFG_BAR_TOP:    bar_top_q    <= cfg_i.data[ROW_W-1:0];
        CFG_BAR_HEIGHT: bar_height_q <= cfg_i.data[6:0];
        CFG_SEGMENTED:  segmented_q  <= cfg_i.data[0];
        CFG_RAM_OFFSET: ram_offset_q <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // effective width, height and bottom row
  always_comb begin
    w_eff = bar_width_q;
    if (w_eff == '0) w_eff = 8'd1;
    if (w_eff > PanelCols) w_eff = PanelCols;
    h_eff  = (bar_height_q == '0) ? 7'd1 : bar_height_q;
    y1_raw = {2'b00, bar_top_q} + {1'b0, h_eff} - 8'd1;
  end

  bgdsr_span #(
    .PANEL_COLUMNS (PANEL_COLUMNS)
  ) u_span (
    .full_i       (full_q),
    .width_i      (width_q),
    .level_i      (lvl_q),
    .peak_i       (pk_q),
    .prev_level_i (prev_level_q),
    .prev_peak_i  (prev_peak_q),
    .bar_left_i   (bar_left_q),
    .span_o       (span)
  );

  // chunk size and end tests for the current column
  assign remain    = xe_q - xi_q;
  assign row_done  = (remain < COL_W'(BYTES_PER_RESULT));
  assign count     = row_done ? COUNT_W'(remain) + 5'd1 : COUNT_W'(BYTES_PER_RESULT);
  assign item_done = row_done && (pg_q == y1_q[ROW_W-1:3]);
  assign load      = (state_q == S_EMIT) && (!res_valid_q || res_o.ready);
  assign scol_sum  = {2'b00, bar_left_q} + {2'b00, xi_q} + {7'd0, ram_offset_q};

  bgdsr_col_unit u_col (
    .xi_i         (xi_q),
    .count_i      (count),
    .page_i       (pg_q),
    .y0_i         (bar_top_q),
    .y1_i         (y1_q),
    .level_i      (lvl_q),
    .peak_i       (pk_q),
    .segmented_i  (segmented_q),
    .bytes_low_o  (bytes_low),
    .bytes_high_o (bytes_high)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (upd_xfer) state_d = S_CLAMP;
      S_CLAMP: state_d = S_SPAN;
      S_SPAN:  state_d = span.none ? S_IDLE : S_EMIT;
      S_EMIT:  if (load && item_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_level_q <= '0;
      prev_peak_q  <= '0;
      full_q       <= 1'b1;
      first_q      <= 1'b0;
      pg_q         <= '0;
      xi_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SPAN) begin
        prev_level_q <= lvl_q;
        prev_peak_q  <= pk_q;
        full_q       <= 1'b0;
        xi_q         <= span.xs;
        pg_q         <= bar_top_q[ROW_W-1:3];
        first_q      <= 1'b1;
      end else if (load) begin
        if (row_done) begin
          xi_q    <= xs_q;
          pg_q    <= pg_q + 3'd1;
          first_q <= 1'b1;
        end else begin
          xi_q    <= xi_q + COL_W'(BYTES_PER_RESULT);
          first_q <= 1'b0;
        end
      end
    end
  end

  // item payload: raw inputs, clamped values, span ends
  always_ff @(posedge clk_i) begin
    if (upd_xfer) begin
      lvl_in_q <= upd_i.level;
      pk_in_q  <= upd_i.peak;
    end
    if (state_q == S_CLAMP) begin
      width_q <= w_eff;
      lvl_q   <= (lvl_in_q > w_eff) ? w_eff : lvl_in_q;
      pk_q    <= (pk_in_q > w_eff) ? w_eff : pk_in_q;
      y1_q    <= (y1_raw > 8'd63) ? 6'd63 : y1_raw[ROW_W-1:0];
    end
    if (state_q == S_SPAN) begin
      xs_q <= span.xs;
      xe_q <= span.xe;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_page_q   <= pg_q;
      res_scol_q   <= scol_sum[SCOL_W-1:0];
      res_count_q  <= count;
      res_low_q    <= bytes_low;
      res_high_q   <= bytes_high;
      res_pstart_q <= first_q;
      res_last_q   <= item_done;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.page         = res_page_q;
  assign res_o.start_column = res_scol_q;
  assign res_o.byte_count   = res_count_q;
  assign res_o.bytes_low    = res_low_q;
  assign res_o.bytes_high   = res_high_q;
  assign res_o.page_start   = res_pstart_q;
  assign res_o.last         = res_last_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_count_q != '0 && res_count_q <= COUNT_W'(BYTES_PER_RESULT)))
    else $error("result byte count out of range");

  a_cursor_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (xi_q <= xe_q && xs_q <= xe_q))
    else $error("column cursor left the dirty span");

  a_update_starts_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_xfer |=> (state_q == S_CLAMP && !full_q == $past(!full_q)))
    else $error("update transfer did not start the sequencer");

  a_redraw_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == S_SPAN) |-> !full_q)
    else $error("full redraw flag not cleared after the span step");

endmodule
